// ===== src/spl_pkg.sv =====
// ----------------------------------------------------------------------------
// spl_pkg
// Shared types and constants for the sorted priority list.
// ----------------------------------------------------------------------------
package spl_pkg;

	// list capacity and derived widths
	localparam int DEPTH  = 64;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);

	// payload field widths
	localparam int OPC_W  = 3;
	localparam int KEY_W  = 16;
	localparam int HDL_W  = 16;
	localparam int POS_W  = 7;
	localparam int STS_W  = 2;
	localparam int OCNT_W = 7;

	// compare width for position against fill count
	localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

	// opcodes
	localparam logic [OPC_W-1:0] OP_INSERT    = 3'd0;
	localparam logic [OPC_W-1:0] OP_READ_AT   = 3'd1;
	localparam logic [OPC_W-1:0] OP_RM_FIRST  = 3'd2;
	localparam logic [OPC_W-1:0] OP_RM_LAST   = 3'd3;
	localparam logic [OPC_W-1:0] OP_RM_AT     = 3'd4;

	// status codes
	localparam logic [STS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STS_W-1:0] ST_INVALID   = 2'd1;
	localparam logic [STS_W-1:0] ST_FULL      = 2'd2;

	// one stored entry
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [HDL_W-1:0] handle;
	} entry_t;

	// memory access request from the sequencer
	typedef struct packed {
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		entry_t            wr_data;
	} store_req_t;

	// one result item
	typedef struct packed {
		logic [STS_W-1:0]  status;
		logic [KEY_W-1:0]  key;
		logic [HDL_W-1:0]  handle;
		logic [OCNT_W-1:0] count;
	} result_t;

endpackage

// ===== src/spl_if.sv =====
// ----------------------------------------------------------------------------
// spl_if
// Valid/ready channels for commands into and results out of the list.
// ----------------------------------------------------------------------------
interface spl_cmd_if;
	logic                      valid;
	logic                      ready;
	logic [spl_pkg::OPC_W-1:0] opcode;
	logic [spl_pkg::KEY_W-1:0] sort_key;
	logic [spl_pkg::HDL_W-1:0] entry_handle;
	logic [spl_pkg::POS_W-1:0] position;

	modport source (output valid, opcode, sort_key, entry_handle, position, input ready);
	modport sink   (input valid, opcode, sort_key, entry_handle, position, output ready);
endinterface

interface spl_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [spl_pkg::STS_W-1:0]  status;
	logic [spl_pkg::KEY_W-1:0]  key_out;
	logic [spl_pkg::HDL_W-1:0]  handle_out;
	logic [spl_pkg::OCNT_W-1:0] entry_count;

	modport source (output valid, status, key_out, handle_out, entry_count, input ready);
	modport sink   (input valid, status, key_out, handle_out, entry_count, output ready);
endinterface

// ===== src/spl_store.sv =====
// ----------------------------------------------------------------------------
// spl_store
// Entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module spl_store (
	input  logic                clk,
	input  spl_pkg::store_req_t req,
	output spl_pkg::entry_t     rd_data
);

	spl_pkg::entry_t mem [spl_pkg::DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
	end

	// read port, registered, holds when idle
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data <= mem[req.rd_addr];
		end
	end

endmodule

// ===== src/spl_seq.sv =====
// ----------------------------------------------------------------------------
// spl_seq
// Command sequencer: walks the entry memory to insert, read and remove,
// shifting entries one per cycle, and builds the result.
// ----------------------------------------------------------------------------
module spl_seq (
	input  logic                     clk,
	input  logic                     arst_n,
	spl_cmd_if.sink                  cmd,
	output spl_pkg::store_req_t      req,
	input  spl_pkg::entry_t          rd_data,
	input  logic                     res_free,
	output logic                     res_valid,
	output spl_pkg::result_t         res
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_INS,
		S_SCAN,
		S_FIN
	} state_t;

	state_t                         state_q;
	logic [spl_pkg::CNT_W-1:0]      count_q;
	logic [spl_pkg::KEY_W-1:0]      key_q;
	logic [spl_pkg::HDL_W-1:0]      handle_q;
	logic                           rm_q;
	logic [spl_pkg::ADDR_W-1:0]     hi_q;
	logic [spl_pkg::ADDR_W-1:0]     scan_q;
	logic                           live_q;
	logic                           first_q;
	logic                           pend_s1;
	logic                           first_s1;
	logic [spl_pkg::ADDR_W-1:0]     pend_addr_s1;
	spl_pkg::result_t               res_q;

	logic                           accept;
	logic                           empty;
	logic                           full;
	logic                           pos_ok;
	logic [spl_pkg::ADDR_W-1:0]     pos_idx;
	logic [spl_pkg::ADDR_W-1:0]     last_idx;
	logic                           ins_gt;
	logic                           ins_move;
	logic                           ins_place;
	logic                           ins_read;
	logic                           scan_read;
	logic                           scan_move;
	logic                           scan_done;

	assign cmd.ready = (state_q == S_IDLE);
	assign accept    = cmd.valid && cmd.ready;
	assign res_valid = (state_q == S_FIN) && res_free;
	assign res       = res_q;

	// decode helpers
	assign empty    = (count_q == '0);
	assign full     = (count_q == spl_pkg::CNT_W'(spl_pkg::DEPTH));
	assign pos_ok   = (cmd.position != '0) &&
	                  (spl_pkg::CMP_W'(cmd.position) <= spl_pkg::CMP_W'(count_q));
	assign pos_idx  = spl_pkg::ADDR_W'(cmd.position - spl_pkg::POS_W'(1));
	assign last_idx = spl_pkg::ADDR_W'(count_q - spl_pkg::CNT_W'(1));

	// walk control
	always_comb begin
		ins_gt    = pend_s1 && (rd_data.key > key_q);
		ins_move  = (state_q == S_INS) && ins_gt;
		ins_place = (state_q == S_INS) &&
		            ((pend_s1 && !ins_gt) || (!pend_s1 && !live_q));
		ins_read  = (state_q == S_INS) && live_q && !ins_place;
		scan_read = (state_q == S_SCAN) && live_q;
		scan_move = (state_q == S_SCAN) && pend_s1 && !first_s1 && rm_q;
		scan_done = (state_q == S_SCAN) && pend_s1 && !live_q;

		req         = '0;
		req.rd_en   = ins_read || scan_read;
		req.rd_addr = scan_q;
		if (ins_move) begin
			// larger key moves up one place
			req.wr_en   = 1'b1;
			req.wr_addr = pend_addr_s1 + spl_pkg::ADDR_W'(1);
			req.wr_data = rd_data;
		end else if (ins_place) begin
			req.wr_en        = 1'b1;
			req.wr_addr      = pend_s1 ? pend_addr_s1 + spl_pkg::ADDR_W'(1) : '0;
			req.wr_data.key    = key_q;
			req.wr_data.handle = handle_q;
		end else if (scan_move) begin
			// close the gap left by the removed entry
			req.wr_en   = 1'b1;
			req.wr_addr = pend_addr_s1 - spl_pkg::ADDR_W'(1);
			req.wr_data = rd_data;
		end
	end

	// state and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			live_q       <= 1'b0;
			first_q      <= 1'b0;
			pend_s1      <= 1'b0;
			first_s1     <= 1'b0;
			rm_q         <= 1'b0;
			key_q        <= '0;
			handle_q     <= '0;
			hi_q         <= '0;
			scan_q       <= '0;
			pend_addr_s1 <= '0;
			res_q        <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						key_q        <= cmd.sort_key;
						handle_q     <= cmd.entry_handle;
						pend_s1      <= 1'b0;
						first_q      <= 1'b1;
						res_q.status <= spl_pkg::ST_INVALID;
						res_q.key    <= '0;
						res_q.handle <= '0;
						res_q.count  <= spl_pkg::OCNT_W'(count_q);
						unique case (cmd.opcode)
							spl_pkg::OP_INSERT: begin
								if (full) begin
									res_q.status <= spl_pkg::ST_FULL;
									state_q      <= S_FIN;
								end else begin
									scan_q  <= last_idx;
									live_q  <= !empty;
									state_q <= S_INS;
								end
							end
							spl_pkg::OP_READ_AT: begin
								rm_q    <= 1'b0;
								scan_q  <= pos_idx;
								hi_q    <= pos_idx;
								live_q  <= 1'b1;
								state_q <= pos_ok ? S_SCAN : S_FIN;
							end
							spl_pkg::OP_RM_FIRST: begin
								rm_q    <= 1'b1;
								scan_q  <= '0;
								hi_q    <= last_idx;
								live_q  <= 1'b1;
								state_q <= empty ? S_FIN : S_SCAN;
							end
							spl_pkg::OP_RM_LAST: begin
								rm_q    <= 1'b1;
								scan_q  <= last_idx;
								hi_q    <= last_idx;
								live_q  <= 1'b1;
								state_q <= empty ? S_FIN : S_SCAN;
							end
							spl_pkg::OP_RM_AT: begin
								rm_q    <= 1'b1;
								scan_q  <= pos_idx;
								hi_q    <= last_idx;
								live_q  <= 1'b1;
								state_q <= pos_ok ? S_SCAN : S_FIN;
							end
							default: begin
								state_q <= S_FIN;
							end
						endcase
					end
				end
				S_INS: begin
					// descending walk from the tail until a key not above the new one
					pend_s1      <= ins_read;
					pend_addr_s1 <= scan_q;
					if (ins_read) begin
						scan_q <= scan_q - spl_pkg::ADDR_W'(1);
						live_q <= (scan_q != '0);
					end
					if (ins_place) begin
						count_q      <= count_q + spl_pkg::CNT_W'(1);
						res_q.status <= spl_pkg::ST_OK;
						res_q.count  <= spl_pkg::OCNT_W'(count_q + spl_pkg::CNT_W'(1));
						state_q      <= S_FIN;
					end
				end
				S_SCAN: begin
					// ascending walk from the target to the end of the range
					pend_s1 <= scan_read;
					if (scan_read) begin
						pend_addr_s1 <= scan_q;
						scan_q       <= scan_q + spl_pkg::ADDR_W'(1);
						live_q       <= (scan_q != hi_q);
						first_s1     <= first_q;
						first_q      <= 1'b0;
					end
					if (pend_s1 && first_s1) begin
						res_q.key    <= rd_data.key;
						res_q.handle <= rd_data.handle;
					end
					if (scan_done) begin
						if (rm_q) begin
							count_q     <= count_q - spl_pkg::CNT_W'(1);
							res_q.count <= spl_pkg::OCNT_W'(count_q - spl_pkg::CNT_W'(1));
						end
						res_q.status <= spl_pkg::ST_OK;
						state_q      <= S_FIN;
					end
				end
				S_FIN: begin
					if (res_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== src/sorted_priority_list.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_list
// Stable ascending-key priority list held in a single-port-pair memory.
// ----------------------------------------------------------------------------
// Each command gives exactly one result. Commands run one at a time; the
// next command is taken while the previous result still sits in the output
// register. Timing is set by the memory walk, one entry per cycle: read at
// a position and remove last touch a single entry; remove at position p (or
// remove first, p = 1) walks from p to the end of the list; insert walks
// down from the tail past every entry with a larger key. Rejected commands
// (full, empty, bad position, unknown opcode) go straight to the result
// without a walk. The next command can be taken once the result has entered
// the output register. Memory needs no clearing after reset: only entries
// below the fill count are ever read.
// ----------------------------------------------------------------------------
module sorted_priority_list (
	input  logic      clk,
	input  logic      arst_n,
	spl_cmd_if.sink   cmd,
	spl_rsp_if.source rsp
);

	spl_pkg::store_req_t req;
	spl_pkg::entry_t     rd_data;
	spl_pkg::result_t    res;
	spl_pkg::result_t    out_q;
	logic                res_valid;
	logic                res_free;
	logic                valid_q;

	spl_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req       (req),
		.rd_data   (rd_data),
		.res_free  (res_free),
		.res_valid (res_valid),
		.res       (res)
	);

	spl_store u_store (
		.clk     (clk),
		.req     (req),
		.rd_data (rd_data)
	);

	// output register, free when empty or being drained
	assign res_free = !valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_valid) begin
			valid_q <= 1'b1;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign rsp.valid       = valid_q;
	assign rsp.status      = out_q.status;
	assign rsp.key_out     = out_q.key;
	assign rsp.handle_out  = out_q.handle;
	assign rsp.entry_count = out_q.count;

endmodule

// ===== verif/tb_sorted_priority_list.sv =====
// ----------------------------------------------------------------------------
// tb_sorted_priority_list
// Self-checking bench for the sorted priority list. A shadow copy of the list
// is kept as two queues in key order; every accepted command updates it and
// queues the result it should produce, and each result transfer is checked
// field by field against the oldest queued result. Stimulus starts with a
// directed pass over the corner cases, then runs phases that fill, churn and
// drain the list, with bursty input, random output stalls, long back-pressure
// stretches and drain pauses.
// ----------------------------------------------------------------------------
module tb_sorted_priority_list;
	timeunit 1ns;
	timeprecision 1ps;

	import spl_pkg::*;

	// opcodes the block does not define
	localparam logic [OPC_W-1:0] OP_UNUSED_A = 3'd5;
	localparam logic [OPC_W-1:0] OP_UNUSED_B = 3'd6;
	localparam logic [OPC_W-1:0] OP_UNUSED_C = 3'd7;

	localparam int IDLE_LIMIT   = 4000;
	localparam int TAIL_CYCLES  = 80;
	localparam int HOLD_CYCLES  = 600;
	localparam int HOLD_AT_A    = 1500;
	localparam int HOLD_AT_B    = 25000;
	localparam int RANDOM_ITEMS = 2000;
	localparam int PHASE_ITEMS  = 250;
	localparam int MAX_REPORTS  = 10;

	typedef enum {MIX_FILL, MIX_BALANCED, MIX_DRAIN} mix_t;

	// shadow list plus the queue of results still owed by the block
	class list_tracker;
		logic [KEY_W-1:0] keys[$];
		logic [HDL_W-1:0] handles[$];
		result_t          owed[$];
		int unsigned      errors;

		function void report(string msg);
			errors++;
			if (errors <= MAX_REPORTS)
				$display("[%0t] MISMATCH: %s", $realtime, msg);
		endfunction

		// take the entry at idx out of the list and return it in r
		function void pull(int idx, inout result_t r);
			r.key    = keys[idx];
			r.handle = handles[idx];
			r.status = ST_OK;
			keys.delete(idx);
			handles.delete(idx);
		endfunction

		function void take_command(logic [OPC_W-1:0] op, logic [KEY_W-1:0] key,
				logic [HDL_W-1:0] hdl, logic [POS_W-1:0] pos);
			result_t r;
			int      slot;
			r.status = ST_INVALID;
			r.key    = '0;
			r.handle = '0;
			case (op)
				OP_INSERT: begin
					if (keys.size() >= DEPTH) begin
						r.status = ST_FULL;
					end else begin
						// stable: go after every equal key
						slot = 0;
						while (slot < keys.size() && keys[slot] <= key)
							slot++;
						keys.insert(slot, key);
						handles.insert(slot, hdl);
						r.status = ST_OK;
					end
				end
				OP_READ_AT: begin
					if (pos >= 1 && pos <= keys.size()) begin
						r.key    = keys[pos - 1];
						r.handle = handles[pos - 1];
						r.status = ST_OK;
					end
				end
				OP_RM_FIRST: begin
					if (keys.size() > 0)
						pull(0, r);
				end
				OP_RM_LAST: begin
					if (keys.size() > 0)
						pull(keys.size() - 1, r);
				end
				OP_RM_AT: begin
					if (pos >= 1 && pos <= keys.size())
						pull(pos - 1, r);
				end
				default: ;
			endcase
			r.count = OCNT_W'(keys.size());
			owed.push_back(r);
		endfunction

		function void match_result(result_t got);
			result_t want;
			if (owed.size() == 0) begin
				report($sformatf("unexpected result sts=%0d key=%h hdl=%h cnt=%0d",
					got.status, got.key, got.handle, got.count));
				return;
			end
			want = owed.pop_front();
			if (got.status !== want.status || got.key !== want.key ||
					got.handle !== want.handle || got.count !== want.count)
				report($sformatf("exp sts=%0d key=%h hdl=%h cnt=%0d, got sts=%0d key=%h hdl=%h cnt=%0d",
					want.status, want.key, want.handle, want.count,
					got.status, got.key, got.handle, got.count));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	int          gen_count;
	int          burst_left;
	result_t     rsp_seen;
	list_tracker tracker = new;

	spl_cmd_if cmd_ch ();
	spl_rsp_if rsp_ch ();

	sorted_priority_list dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	always #6 clk = ~clk;

	// transfer monitor: feed the tracker, check results
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_ch.valid && cmd_ch.ready)
				tracker.take_command(cmd_ch.opcode, cmd_ch.sort_key,
					cmd_ch.entry_handle, cmd_ch.position);
			if (rsp_ch.valid && rsp_ch.ready) begin
				rsp_seen.status = rsp_ch.status;
				rsp_seen.key    = rsp_ch.key_out;
				rsp_seen.handle = rsp_ch.handle_out;
				rsp_seen.count  = rsp_ch.entry_count;
				tracker.match_result(rsp_seen);
			end
		end
	end

	// watchdog: too long without any transfer ends the run
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("tb_sorted_priority_list NOT OK");
		$finish;
	end

	// result side: segments of different stall density, two long hold-offs
	initial begin
		int unsigned seg_left;
		int unsigned stall_pct;
		int          cyc;
		rsp_ch.ready = 1'b0;
		seg_left  = 0;
		stall_pct = 0;
		cyc       = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			cyc++;
			if (cyc == HOLD_AT_A || cyc == HOLD_AT_B) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				cyc += HOLD_CYCLES;
			end
			if (seg_left == 0) begin
				case ($urandom_range(0, 2))
					0: stall_pct = 0;
					1: stall_pct = 35;
					default: stall_pct = 75;
				endcase
				seg_left = $urandom_range(10, 200);
			end
			seg_left--;
			rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// one command transfer; called and returns at a falling edge
	task automatic send_command(input logic [OPC_W-1:0] op, input logic [KEY_W-1:0] key,
			input logic [HDL_W-1:0] hdl, input logic [POS_W-1:0] pos);
		cmd_ch.valid        <= 1'b1;
		cmd_ch.opcode       <= op;
		cmd_ch.sort_key     <= key;
		cmd_ch.entry_handle <= hdl;
		cmd_ch.position     <= pos;
		do @(posedge clk); while (!cmd_ch.ready);
		@(negedge clk);
	endtask

	// send one command, keep the fill estimate, and insert gaps between bursts
	task automatic issue(input logic [OPC_W-1:0] op, input logic [KEY_W-1:0] key,
			input logic [HDL_W-1:0] hdl, input logic [POS_W-1:0] pos);
		send_command(op, key, hdl, pos);
		case (op)
			OP_INSERT: if (gen_count < DEPTH) gen_count++;
			OP_RM_FIRST, OP_RM_LAST: if (gen_count > 0) gen_count--;
			OP_RM_AT: if (pos >= 1 && pos <= gen_count) gen_count--;
			default: ;
		endcase
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			if ($urandom_range(0, 9) < 6) begin
				cmd_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250)
				: $urandom_range(0, 30);
		end
	endtask

	// stop offering and let every owed result come back
	task automatic wait_all_results();
		cmd_ch.valid <= 1'b0;
		do @(negedge clk); while (tracker.owed.size() != 0);
	endtask

	function automatic logic [KEY_W-1:0] pick_key();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 1) ? '1 : '0;
			1: return KEY_W'(16'h4000 + $urandom_range(0, 3));   // many equal keys
			default: return KEY_W'($urandom);
		endcase
	endfunction

	// mostly a live position, sometimes zero, one past the end or anything
	function automatic logic [POS_W-1:0] pick_position(int cnt);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (cnt > 0 && r < 80)
			return POS_W'($urandom_range(1, cnt));
		case (r % 4)
			0: return '0;
			1: return POS_W'(cnt + 1);
			2: return '1;
			default: return POS_W'($urandom);
		endcase
	endfunction

	function automatic logic [OPC_W-1:0] pick_opcode(mix_t mix);
		int unsigned r;
		int unsigned ins_pct;
		r = $urandom_range(0, 99);
		ins_pct = (mix == MIX_FILL) ? 80 : (mix == MIX_DRAIN) ? 20 : 45;
		if (r < 2)
			return OPC_W'($urandom_range(OP_UNUSED_A, OP_UNUSED_C));
		if (r < 2 + ins_pct)
			return OP_INSERT;
		case ($urandom_range(0, 4))
			0: return OP_READ_AT;
			1: return OP_RM_FIRST;
			2: return OP_RM_LAST;
			default: return OP_RM_AT;
		endcase
	endfunction

	initial begin
		mix_t mix;
		arst_n              = 1'b0;
		cmd_ch.valid        = 1'b0;
		cmd_ch.opcode       = OP_INSERT;
		cmd_ch.sort_key     = '0;
		cmd_ch.entry_handle = '0;
		cmd_ch.position     = '0;
		gen_count           = 0;
		burst_left          = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty list, unused opcodes
		issue(OP_RM_FIRST, '0, '0, '0);
		issue(OP_RM_LAST, '0, '0, '0);
		issue(OP_READ_AT, '0, '0, 7'd1);
		issue(OP_RM_AT, '0, '0, '0);
		issue(OP_UNUSED_A, '1, '1, '1);
		issue(OP_UNUSED_B, '0, '0, '0);
		issue(OP_UNUSED_C, '1, '1, '1);
		// key extremes and ties keep insertion order
		issue(OP_INSERT, 16'h0000, 16'hFFFF, '1);
		issue(OP_INSERT, 16'hFFFF, 16'h0000, '0);
		issue(OP_INSERT, 16'h8000, 16'h1234, '0);
		issue(OP_INSERT, 16'h8000, 16'h5678, '0);
		issue(OP_INSERT, 16'h0000, 16'h0001, '0);
		// reads: zero, first, last, one past, top of field
		issue(OP_READ_AT, '0, '0, 7'd0);
		issue(OP_READ_AT, '0, '0, 7'd1);
		issue(OP_READ_AT, '0, '0, 7'd5);
		issue(OP_READ_AT, '0, '0, 7'd6);
		issue(OP_READ_AT, '0, '0, '1);
		// removals in each form, bad positions
		issue(OP_RM_AT, '0, '0, 7'd3);
		issue(OP_RM_AT, '0, '0, 7'd0);
		issue(OP_RM_AT, '0, '0, 7'd5);
		issue(OP_RM_FIRST, '0, '0, '0);
		issue(OP_RM_LAST, '0, '0, '0);
		issue(OP_RM_AT, '0, '0, 7'd2);

		// random phases: fill to full, churn, drain to empty
		for (int ph = 0; ph < RANDOM_ITEMS / PHASE_ITEMS; ph++) begin
			mix = mix_t'(ph % 3);
			for (int n = 0; n < PHASE_ITEMS; n++)
				issue(pick_opcode(mix), pick_key(), HDL_W'($urandom), pick_position(gen_count));
			if (ph == 2 || ph == 5)
				wait_all_results();
		end

		wait_all_results();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (tracker.errors == 0)
			$display("tb_sorted_priority_list OK");
		else
			$display("tb_sorted_priority_list NOT OK");
		$finish;
	end

endmodule
